@@ src/tnli_pkg.sv @@
// ----------------------------------------------------------------------------
// tnli_pkg
// shared types, codes and sizes of the time node linear interpolator
// ----------------------------------------------------------------------------
package tnli_pkg;

    localparam int DEF_MAX_NODES    = 64;
    localparam int DEF_MAX_ELEMENTS = 32;
    localparam int RESULT_CAP       = 32;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_STEP   = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic CFG_NODES    = 1'b0;
    localparam logic CFG_ELEMENTS = 1'b1;

    // classified beat handed from front to back
    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  node;
        logic [4:0]  element;
        logic [31:0] sample;
        logic [23:0] step_length;
        logic [31:0] query_time;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_WALK_RD,
        ST_DIV,
        ST_PREV_RD,
        ST_NEXT_RD,
        ST_MUL,
        ST_EMIT,
        ST_OOR
    } back_state_t;

endpackage

@@ src/tnli_front.sv @@
// ----------------------------------------------------------------------------
// tnli_front
// two-entry queue of input beats toward the back end
// ----------------------------------------------------------------------------
module tnli_front
    import tnli_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  cmd_t s_cmd,
    output logic q_valid,
    input  logic q_ready,
    output cmd_t q_cmd,
    output logic busy
);

    cmd_t       buf_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    // unused action codes are dropped here
    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready && (s_cmd.action != 2'd3);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = buf_reg[rd_ptr_reg];
    assign pop     = q_valid && q_ready;
    assign busy    = q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= s_cmd;
        end
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("queue lost an entry");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");

endmodule

@@ src/tnli_back.sv @@
// ----------------------------------------------------------------------------
// tnli_back
// table storage, boundary walk, weight divider and element interpolation
// ----------------------------------------------------------------------------
module tnli_back
    import tnli_pkg::*;
#(
    parameter int MAX_NODES    = DEF_MAX_NODES,
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    input  logic [6:0]  active_nodes,
    input  logic [5:0]  active_elements,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_elem,
    output logic [31:0] m_value,
    output logic        m_status,
    output logic        m_last,
    output logic        busy
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int EW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int AW  = NW + EW;
    localparam int ECAP = (MAX_ELEMENTS < RESULT_CAP) ? MAX_ELEMENTS : RESULT_CAP;

    // one power-of-two slot row per node
    logic [31:0] smem [2**AW];
    logic [23:0] tmem [MAX_NODES];
    logic [31:0] s_rd_reg;
    logic [23:0] t_rd_reg;

    back_state_t state_reg, state_next;
    logic [NW:0]  i_reg, i_next, nn_reg, nn_next;
    logic [5:0]   e_reg, e_next, ne_reg, ne_next;
    logic [32:0]  tally_reg, tally_next;
    logic [23:0]  dur_reg, dur_next;
    logic [40:0]  rem_reg, rem_next;
    logic [16:0]  w_reg, w_next;
    logic [4:0]   dcnt_reg, dcnt_next;
    logic [31:0]  prev_reg, prev_next;
    logic [32:0]  diff_reg, diff_next;
    logic [50:0]  prod_reg, prod_next;
    logic         s_rd_en, t_rd_en;
    logic [AW-1:0] s_addr;
    logic [NW-1:0] t_addr;
    logic [NW-1:0] wr_node;
    logic [EW-1:0] wr_elem;
    logic         load;

    // output register
    logic         ov_reg;
    logic [4:0]   oe_reg;
    logic [31:0]  oval_reg;
    logic         ost_reg, olast_reg;
    logic         ov_set;
    logic [4:0]   oe_in;
    logic [31:0]  oval_in;
    logic         ost_in, olast_in;

    logic [32:0]  start;
    logic [40:0]  rem_sh;
    logic [40:0]  dsub;
    logic [32:0]  qt;

    assign qt      = {1'b0, q_cmd.query_time};
    assign start   = tally_reg - {9'd0, dur_reg};
    assign rem_sh  = {rem_reg[39:0], 1'b0};
    assign dsub    = rem_sh - {17'd0, dur_reg};
    assign wr_node = NW'(q_cmd.node);
    assign wr_elem = EW'(q_cmd.element);
    assign load    = state_reg == ST_IDLE && q_valid;
    assign q_ready = (state_reg == ST_EMIT && !ov_reg && e_reg + 6'd1 == ne_reg)
                     || (state_reg == ST_OOR && !ov_reg)
                     || (load && q_cmd.action != ACT_QUERY);
    assign busy    = state_reg != ST_IDLE || ov_reg;

    always_ff @(posedge aclk) begin
        if (load && q_cmd.action == ACT_SAMPLE
            && {26'd0, q_cmd.node} < MAX_NODES && {27'd0, q_cmd.element} < MAX_ELEMENTS) begin
            smem[{wr_node, wr_elem}] <= q_cmd.sample;
        end
        if (load && q_cmd.action == ACT_STEP && {26'd0, q_cmd.node} < MAX_NODES) begin
            tmem[wr_node] <= q_cmd.step_length;
        end
        if (s_rd_en) s_rd_reg <= smem[s_addr];
        if (t_rd_en) t_rd_reg <= tmem[t_addr];
    end

    always_comb begin
        state_next = state_reg;
        i_next = i_reg; nn_next = nn_reg; e_next = e_reg; ne_next = ne_reg;
        tally_next = tally_reg; dur_next = dur_reg; rem_next = rem_reg;
        w_next = w_reg; dcnt_next = dcnt_reg; prev_next = prev_reg;
        diff_next = diff_reg; prod_next = prod_reg;
        s_rd_en = 1'b0; t_rd_en = 1'b0;
        s_addr = '0; t_addr = '0;
        ov_set = 1'b0; oe_in = '0; oval_in = '0; ost_in = 1'b0; olast_in = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (load && q_cmd.action == ACT_QUERY) begin
                    if (active_nodes < 7'd2) nn_next = (NW+1)'(2);
                    else if ({25'd0, active_nodes} > MAX_NODES) nn_next = (NW+1)'(MAX_NODES);
                    else nn_next = (NW+1)'(active_nodes);
                    if (active_elements == 6'd0) ne_next = 6'd1;
                    else if ({26'd0, active_elements} > ECAP) ne_next = 6'(ECAP);
                    else ne_next = active_elements;
                    i_next = '0;
                    tally_next = '0;
                    t_rd_en = 1'b1;
                    t_addr = '0;
                    state_next = ST_WALK;
                end
            end
            // t_rd_reg holds step(i); tally becomes boundary B(i+1)
            ST_WALK: begin
                tally_next = tally_reg + {9'd0, t_rd_reg};
                dur_next = t_rd_reg;
                i_next = i_reg + 1'b1;
                state_next = ST_WALK_RD;
            end
            ST_WALK_RD: begin
                if (i_reg == nn_reg) begin
                    state_next = ST_OOR;
                end else if (qt < tally_reg) begin
                    // segment from node i-1 to node i
                    if (dur_reg == 24'd0 || qt < start) begin
                        w_next = '0;
                        e_next = '0;
                        state_next = ST_PREV_RD;
                        s_rd_en = 1'b1;
                        s_addr = {i_reg[NW-1:0] - 1'b1, {EW{1'b0}}};
                    end else begin
                        rem_next = {8'd0, qt - start};
                        w_next = '0;
                        dcnt_next = '0;
                        state_next = ST_DIV;
                    end
                end else begin
                    t_rd_en = 1'b1;
                    t_addr = i_reg[NW-1:0];
                    state_next = ST_WALK;
                end
            end
            // restoring division: ((t-S)<<16)/dur, remainder kept in rem
            ST_DIV: begin
                if (dsub[40] == 1'b0) begin
                    rem_next = dsub;
                    w_next = {w_reg[15:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    w_next = {w_reg[15:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd15) begin
                    e_next = '0;
                    s_rd_en = 1'b1;
                    s_addr = {i_reg[NW-1:0] - 1'b1, {EW{1'b0}}};
                    state_next = ST_PREV_RD;
                end
            end
            ST_PREV_RD: begin
                prev_next = s_rd_reg;
                s_rd_en = 1'b1;
                s_addr = {i_reg[NW-1:0], e_reg[EW-1:0]};
                state_next = ST_NEXT_RD;
            end
            ST_NEXT_RD: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                diff_next = {s_rd_reg[31], s_rd_reg} - {prev_reg[31], prev_reg};
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                prod_next = 51'($signed({1'b0, (w_reg > 17'd65536) ? 17'd65536 : w_reg})
                               * $signed(diff_reg));
                if (!ov_reg) begin
                    ov_set = 1'b1;
                    oe_in = e_reg[4:0];
                    oval_in = prev_reg + 32'($signed(prod_next) >>> 16);
                    olast_in = (e_reg + 6'd1 == ne_reg);
                    if (olast_in) begin
                        state_next = ST_IDLE;
                    end else begin
                        e_next = e_reg + 6'd1;
                        s_rd_en = 1'b1;
                        s_addr = {i_reg[NW-1:0] - 1'b1, e_next[EW-1:0]};
                        state_next = ST_PREV_RD;
                    end
                end
            end
            ST_OOR: begin
                if (!ov_reg) begin
                    ov_set = 1'b1; ost_in = 1'b1; olast_in = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next; nn_reg <= nn_next; e_reg <= e_next; ne_reg <= ne_next;
        tally_reg <= tally_next; dur_reg <= dur_next; rem_reg <= rem_next;
        w_reg <= w_next; dcnt_reg <= dcnt_next; prev_reg <= prev_next;
        diff_reg <= diff_next; prod_reg <= prod_next;
        if (ov_set) begin
            oe_reg <= oe_in; oval_reg <= oval_in; ost_reg <= ost_in; olast_reg <= olast_in;
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ov_set) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
        end
    end

    assign m_valid  = ov_reg;
    assign m_elem   = oe_reg;
    assign m_value  = oval_reg;
    assign m_status = ost_reg;
    assign m_last   = olast_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) ov_set |-> !ov_reg)
        else $error("result register overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> dcnt_reg <= 5'd15)
        else $error("divider ran past its last step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_set && ost_in) |-> olast_in)
        else $error("status beat without last");

endmodule

@@ src/time_node_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// time_node_linear_interpolator
// piecewise linear interpolation over a table of timed trajectory nodes
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_axis   in   s_tvalid/s_tready    tdata: action,node,element,sample,step,time
// m_axis   out  m_tvalid/m_tready    tdata: elem_index,value  tuser: status  tlast
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a query walks the nodes one by one (one step-table read and add each),
// runs the restoring weight divider, then handles each element in turn
// from the single sample-table read port.
// reset clears control only; tables are undefined until written.
// a stalled result holds the back end; the front queue keeps taking beats
// until its two entries are full.
// ----------------------------------------------------------------------------
module time_node_linear_interpolator
    import tnli_pkg::*;
#(
    parameter int MAX_NODES    = DEF_MAX_NODES,
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[1:0], node[7:2], element[12:8], sample[44:13], step_length[68:45],
    // query_time[100:69], zero pad
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // elem_index[4:0], value[36:5], zero pad
    output logic [39:0]  m_tdata,
    // status
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_data
);

    cmd_t       s_cmd, q_cmd;
    logic       q_valid, q_ready, fbusy, bbusy;
    logic [6:0] an_reg;
    logic [5:0] ae_reg;
    logic [4:0] me;
    logic [31:0] mv;

    assign s_cmd.action      = s_tdata[1:0];
    assign s_cmd.node        = s_tdata[7:2];
    assign s_cmd.element     = s_tdata[12:8];
    assign s_cmd.sample      = s_tdata[44:13];
    assign s_cmd.step_length = s_tdata[68:45];
    assign s_cmd.query_time  = s_tdata[100:69];

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            an_reg <= 7'd64;
            ae_reg <= 6'd32;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_NODES) an_reg <= cfg_data;
            else ae_reg <= cfg_data[5:0];
        end
    end

    tnli_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready), .s_cmd(s_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .busy(fbusy)
    );

    tnli_back #(.MAX_NODES(MAX_NODES), .MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .active_nodes(an_reg), .active_elements(ae_reg),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_elem(me), .m_value(mv), .m_status(m_tuser), .m_last(m_tlast),
        .busy(bbusy)
    );

    assign m_tdata = {3'd0, mv, me};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result beat dropped under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> bbusy)
        else $error("result beat while back end idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> fbusy)
        else $error("input blocked with empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("status beat without last");

endmodule
